>>> rtl/fblrd_pkg.sv
// Shared constants and types for the frame buffer line and rectangle drawer.
package fblrd_pkg;
    localparam int ScreenWidth  = 84;
    localparam int ScreenHeight = 48;
    localparam int BufferBytes  = 504;
    localparam int AddrW        = 9;

    localparam logic [2:0] FUNC_PIXEL = 3'd0;
    localparam logic [2:0] FUNC_LINE  = 3'd1;
    localparam logic [2:0] FUNC_RECT  = 3'd2;
    localparam logic [2:0] FUNC_FILL  = 3'd3;
    localparam logic [2:0] FUNC_CLEAR = 3'd4;
    localparam logic [2:0] FUNC_READ  = 3'd5;

    // one pixel request from the walker to the buffer
    typedef struct packed {
        logic             valid;
        logic             ink;
        logic signed [9:0] x;
        logic signed [9:0] y;
    } t_plot;
endpackage

>>> rtl/fblrd_buffer.sv
// Frame buffer memory with pixel read-modify-write, clear sweep and byte read.
module fblrd_buffer
    import fblrd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_plot            i_plot,
    input  logic             i_clr_start,
    input  logic             i_rd_req,
    input  logic [AddrW-1:0] i_rd_addr,
    output logic             o_busy,
    output logic [7:0]       o_rd_data
);
    logic [7:0] r_mem [BufferBytes];
    logic [7:0] r_q;
    logic             r_clr;
    logic [AddrW-1:0] r_clr_addr;
    logic             r_wb;
    logic [AddrW-1:0] r_wb_addr;
    logic [2:0]       r_wb_bit;
    logic             r_wb_ink;
    logic             r_rd_ok;

    logic             onscreen;
    logic [AddrW-1:0] p_addr;
    logic [7:0]       wdata;
    logic [AddrW-1:0] raddr;

    assign onscreen = i_plot.valid && i_plot.x >= 0 && i_plot.x < ScreenWidth
                      && i_plot.y >= 0 && i_plot.y < ScreenHeight;
    assign p_addr = AddrW'(i_plot.x + (i_plot.y >>> 3) * ScreenWidth);
    assign raddr  = i_rd_req ? i_rd_addr : p_addr;

    always_comb begin
        wdata = r_q;
        wdata[r_wb_bit] = r_wb_ink;
    end

    // read the byte into a register, then write back the modified byte; walker waits on busy
    always_ff @(posedge i_clk) begin
        r_q <= r_mem[raddr];
        if (r_clr) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (r_wb) begin
            r_mem[r_wb_addr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_wb       <= 1'b0;
            r_rd_ok    <= 1'b0;
        end else begin
            r_wb    <= onscreen && !r_wb && !r_clr;
            r_rd_ok <= i_rd_addr < BufferBytes;
            if (r_clr) begin
                if (r_clr_addr == AddrW'(BufferBytes - 1)) r_clr <= 1'b0;
                r_clr_addr <= r_clr_addr + 1'b1;
            end else if (i_clr_start) begin
                r_clr      <= 1'b1;
                r_clr_addr <= '0;
            end
        end
        r_wb_addr <= p_addr;
        r_wb_bit  <= i_plot.y[2:0];
        r_wb_ink  <= i_plot.ink;
    end

    assign o_busy    = r_clr || r_wb;
    assign o_rd_data = r_rd_ok ? r_q : 8'd0;
endmodule

>>> rtl/framebuffer_line_rect_drawer_unit.sv
// Top level of the frame buffer line and rectangle drawer.
// Each command item is taken and answered with one result item. Pixel, line,
// rectangle and fill are walked pixel by pixel through a read-modify-write of
// the 504-byte buffer: an on-screen pixel is read and then written back, an
// off-screen one is skipped without a write, so a command lasts about as long
// as the pixels it visits. A clear sweeps all 504 bytes; a read passes S_RD
// and registers its byte in S_RD2. A new item is held off until the previous
// result has been taken. After reset all 504 bytes are cleared before the first item is taken.
module framebuffer_line_rect_drawer_unit
    import fblrd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_func,
    input  logic signed [7:0] i_x_start,
    input  logic signed [7:0] i_y_start,
    input  logic signed [7:0] i_x_end,
    input  logic signed [7:0] i_y_end,
    input  logic              i_ink,
    input  logic [8:0]        i_byte_index,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_read_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_CLR  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_RD2  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]  r_state;
    logic [2:0]  r_func;
    logic        r_ink;
    logic [8:0]  r_idx;
    logic        r_steep;
    logic signed [9:0] r_x1, r_y1, r_x2, r_y2, r_cx, r_cy, r_dx, r_dy, r_err;
    logic signed [9:0] r_ystep;
    logic [1:0]  r_side;
    logic        r_clr_go;
    logic        r_ovalid;
    logic [7:0]  r_odata;

    t_plot      plot;
    logic       busy;
    logic [7:0] rd_data;
    logic       accept, step, last;
    logic signed [9:0] xs, ys, xe, ye, ax, ay, err_n;

    fblrd_buffer u_buf (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_plot(plot), .i_clr_start(r_clr_go),
        .i_rd_req(r_state == S_RD), .i_rd_addr(r_idx), .o_busy(busy),
        .o_rd_data(rd_data)
    );

    // hold the input while a command runs, the buffer is busy or a result waits
    assign o_stall = r_state != S_IDLE || busy || r_ovalid;
    assign accept  = i_valid && !o_stall;
    assign step    = r_state == S_WALK && !busy;

    assign xs = 10'(i_x_start);
    assign ys = 10'(i_y_start);
    assign xe = 10'(i_x_end);
    assign ye = 10'(i_y_end);
    assign ax = (xe > xs) ? xe - xs : xs - xe;
    assign ay = (ye > ys) ? ye - ys : ys - ye;

    always_comb begin
        plot.valid = step;
        plot.ink   = r_ink;
        plot.x     = r_cx;
        plot.y     = r_cy;
        if (r_func == FUNC_LINE && r_steep) begin
            plot.x = r_cy;
            plot.y = r_cx;
        end
        err_n = r_err - r_dy;
        last  = 1'b0;
        case (r_func)
            FUNC_FILL: last = r_cx == r_x2 && r_cy == r_y2;
            FUNC_RECT: last = r_side == 2'd3 && r_cy == r_y2;
            default:   last = r_cx == r_x2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_clr_go <= 1'b0;
        end else begin
            r_clr_go <= 1'b0;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (accept) begin
                    r_func <= i_func;
                    r_ink  <= i_ink;
                    r_idx  <= i_byte_index;
                    r_side <= 2'd0;
                    unique case (i_func)
                        FUNC_PIXEL: begin
                            r_state <= S_WALK;
                            r_cx <= xs; r_x2 <= xs; r_cy <= ys;
                        end
                        FUNC_LINE: begin
                            r_state <= S_WALK;
                            r_steep <= ay > ax;
                            if (ay > ax) begin
                                if (ys > ye) begin
                                    r_cx <= ye; r_x2 <= ys; r_cy <= xe;
                                    r_ystep <= (xe < xs) ? 10'sd1 : -10'sd1;
                                end else begin
                                    r_cx <= ys; r_x2 <= ye; r_cy <= xs;
                                    r_ystep <= (xs < xe) ? 10'sd1 : -10'sd1;
                                end
                                r_dx <= ay; r_dy <= ax; r_err <= ay >>> 1;
                            end else begin
                                if (xs > xe) begin
                                    r_cx <= xe; r_x2 <= xs; r_cy <= ye;
                                    r_ystep <= (ye < ys) ? 10'sd1 : -10'sd1;
                                end else begin
                                    r_cx <= xs; r_x2 <= xe; r_cy <= ys;
                                    r_ystep <= (ys < ye) ? 10'sd1 : -10'sd1;
                                end
                                r_dx <= ax; r_dy <= ay; r_err <= ax >>> 1;
                            end
                        end
                        FUNC_RECT, FUNC_FILL: begin
                            r_state <= S_WALK;
                            r_x1 <= (xs < xe) ? xs : xe;
                            r_x2 <= (xs < xe) ? xe : xs;
                            r_y1 <= (ys < ye) ? ys : ye;
                            r_y2 <= (ys < ye) ? ye : ys;
                            r_cx <= (xs < xe) ? xs : xe;
                            r_cy <= (ys < ye) ? ys : ye;
                        end
                        FUNC_CLEAR: begin
                            r_state  <= S_CLR;
                            r_clr_go <= 1'b1;
                        end
                        FUNC_READ: r_state <= S_RD;
                        default:   r_state <= S_DONE;
                    endcase
                end
                S_WALK: if (step) begin
                    if (last) begin
                        r_state <= S_DONE;
                    end else begin
                        case (r_func)
                            FUNC_LINE: begin
                                r_cx <= r_cx + 10'sd1;
                                if (err_n < 0) begin
                                    r_cy  <= r_cy + r_ystep;
                                    r_err <= err_n + r_dx;
                                end else begin
                                    r_err <= err_n;
                                end
                            end
                            FUNC_FILL: begin
                                if (r_cy == r_y2) begin
                                    r_cy <= r_y1;
                                    r_cx <= r_cx + 10'sd1;
                                end else begin
                                    r_cy <= r_cy + 10'sd1;
                                end
                            end
                            default: begin
                                // sides: top row, bottom row, left col, right col
                                unique case (r_side)
                                    2'd0, 2'd1: begin
                                        if (r_cx == r_x2) begin
                                            r_side <= r_side + 2'd1;
                                            r_cx   <= (r_side == 2'd0) ? r_x1 : r_x1;
                                            r_cy   <= (r_side == 2'd0) ? r_y2 : r_y1;
                                        end else begin
                                            r_cx <= r_cx + 10'sd1;
                                        end
                                    end
                                    default: begin
                                        if (r_cy == r_y2) begin
                                            r_side <= 2'd3;
                                            r_cx   <= r_x2;
                                            r_cy   <= r_y1;
                                        end else begin
                                            r_cy <= r_cy + 10'sd1;
                                        end
                                    end
                                endcase
                            end
                        endcase
                    end
                end
                S_CLR:  if (!busy && !r_clr_go) r_state <= S_DONE;
                S_RD:   r_state <= S_RD2;
                S_RD2: begin
                    r_odata  <= rd_data;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_DONE: if (!busy && (!r_ovalid || !i_stall)) begin
                    r_odata  <= 8'd0;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_read_data = r_odata;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> o_stall) else $error("item taken while buffer busy");
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |=> r_state == S_RD2) else $error("read sequence broken");
    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && last) |=> r_state == S_DONE) else $error("walk did not finish");
`endif
endmodule
